>>> rtl/core/bmhq_pkg.sv
// Shared types and constants for the binary min-heap queue unit.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package bmhq_pkg;

    localparam int CAPACITY = 32;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Broadcast control from the top level to every cell
    typedef struct packed
    {
        logic                    ins_en;
        logic                    rem_en;
        logic signed [KEY_W-1:0] key;
    } ctl_t;

    // Hand-off from a cell to its right neighbor
    typedef struct packed
    {
        logic                    gt;
        logic signed [KEY_W-1:0] key;
    } link_t;

endpackage

>>> rtl/core/bmhq_cell.sv
// One slot of the sorted key chain: holds one key and trades it with its neighbors.
// Depends on bmhq_pkg (ctl_t, link_t, KEY_W).
module bmhq_cell
(
    input  logic                              clk,
    input  bmhq_pkg::ctl_t                    ctl,
    input  logic                              occ,
    input  bmhq_pkg::link_t                   left,
    input  logic signed [bmhq_pkg::KEY_W-1:0] right_key,
    output bmhq_pkg::link_t                   link
);

    logic signed [bmhq_pkg::KEY_W-1:0] key_reg;
    logic signed [bmhq_pkg::KEY_W-1:0] key_next;
    logic                              gt;

    // On insert this slot takes a key when it is free or holds a larger key than the new one
    assign gt = occ && (key_reg > ctl.key);

    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins_en && (gt || !occ))
        begin
            // take the left key if it shifts right, otherwise take the new key
            key_next = left.gt ? left.key : ctl.key;
        end
        else if (ctl.rem_en)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign link.gt  = gt;
    assign link.key = key_reg;

endmodule

>>> rtl/core/binary_min_heap_queue_unit.sv
// Top level of the min-priority queue: a sorted chain of key cells plus fill count and result register.
// Depends on bmhq_pkg and bmhq_cell.
//
//  beat        handshake              payload
//  command     cmd_valid / cmd_ready  command, value
//  response    rsp_valid / rsp_ready  removed_value, status, entry_count
//
// Every cell compares its key with the new key at once; on insert the cells holding a larger key
// shift right to make room, and on remove every cell shifts left, so the whole chain updates together.
// The response sits in a register; a new command is taken whenever that register is
// empty or being drained in the same cycle.
// Reset clears the fill count and the response valid; cell keys need no reset.
module binary_min_heap_queue_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic                              command,
    input  logic signed [bmhq_pkg::KEY_W-1:0] value,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic signed [bmhq_pkg::KEY_W-1:0] removed_value,
    output logic [1:0]                        status,
    output logic [bmhq_pkg::CNT_W-1:0]        entry_count
);

    logic [bmhq_pkg::CNT_W-1:0]        count_reg;
    logic [bmhq_pkg::CNT_W-1:0]        count_next;
    logic                              rsp_valid_reg;
    logic                              rsp_valid_next;
    logic signed [bmhq_pkg::KEY_W-1:0] removed_reg;
    logic signed [bmhq_pkg::KEY_W-1:0] removed_next;
    bmhq_pkg::status_t                 status_reg;
    bmhq_pkg::status_t                 status_next;
    logic                              accept;
    logic                              is_full;
    logic                              is_empty;
    bmhq_pkg::ctl_t                    ctl;
    bmhq_pkg::link_t                   links [bmhq_pkg::CAPACITY];
    logic [bmhq_pkg::CAPACITY-1:0]     occ;

    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign is_full   = (count_reg == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY));
    assign is_empty  = (count_reg == '0);

    assign ctl.ins_en = accept && (bmhq_pkg::cmd_t'(command) == bmhq_pkg::CMD_INSERT) && !is_full;
    assign ctl.rem_en = accept && (bmhq_pkg::cmd_t'(command) == bmhq_pkg::CMD_REMOVE) && !is_empty;
    assign ctl.key    = value;

    genvar i;
    generate
        for (i = 0; i < bmhq_pkg::CAPACITY; i++)
        begin : g_cell
            bmhq_pkg::link_t                   left_in;
            logic signed [bmhq_pkg::KEY_W-1:0] right_in;

            assign occ[i] = (count_reg > bmhq_pkg::CNT_W'(i));

            if (i == 0)
            begin : g_first
                assign left_in = '0;
            end
            else
            begin : g_mid
                assign left_in = links[i-1];
            end

            if (i == bmhq_pkg::CAPACITY - 1)
            begin : g_last
                assign right_in = '0;
            end
            else
            begin : g_inner
                assign right_in = links[i+1].key;
            end

            bmhq_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .occ       (occ[i]),
                .left      (left_in),
                .right_key (right_in),
                .link      (links[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        removed_next   = removed_reg;
        status_next    = status_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            removed_next   = '0;
            status_next    = bmhq_pkg::ST_OK;
            if (bmhq_pkg::cmd_t'(command) == bmhq_pkg::CMD_INSERT)
            begin
                if (is_full)
                    status_next = bmhq_pkg::ST_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            else
            begin
                if (is_empty)
                begin
                    status_next = bmhq_pkg::ST_EMPTY;
                end
                else
                begin
                    removed_next = links[0].key;
                    count_next   = count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign entry_count   = count_reg;

    // Fill count never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY))
        else $error("fill count above capacity");

    // Head of the chain is no larger than the next key held
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= bmhq_pkg::CNT_W'(2)) |-> (links[0].key <= links[1].key))
        else $error("chain head out of order");

    // A dropped insert leaves the queue full
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == bmhq_pkg::ST_FULL)
        |-> (entry_count == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY)))
        else $error("full status with room left");

    // A rejected remove reports zero on an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == bmhq_pkg::ST_EMPTY)
        |-> (entry_count == '0 && removed_reg == '0))
        else $error("empty status with keys held");

    // The count moves only when a beat is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("fill count changed without a beat");

endmodule
